[rtl/core/creg_status_line_parser_unit_macros.svh]
// Assertion macros shared by the status line parser RTL.
`ifndef CREG_STATUS_LINE_PARSER_UNIT_MACROS_SVH
`define CREG_STATUS_LINE_PARSER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CRSP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("crsp: invariant violated");

// A condition that must hold in the cycle after a trigger.
`define CRSP_ASSERT_NEXT(lbl, trig, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (expr)) \
        else $error("crsp: sequence violated");

`endif

[rtl/core/crsp_pkg.sv]
// Types, constants and helper functions of the status line parser.
`timescale 1ns / 1ps

package crsp_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_PREFIX = 4'd0,
        PH_SEP1   = 4'd1,
        PH_WS1    = 4'd2,
        PH_SIGN1  = 4'd3,
        PH_DIG1   = 4'd4,
        PH_SP1    = 4'd5,
        PH_AFTC   = 4'd6,
        PH_WS2    = 4'd7,
        PH_SIGN2  = 4'd8,
        PH_DIG2   = 4'd9,
        PH_DONE   = 4'd10
    } t_phase;

    // One input transaction: a byte of the line and its end marker.
    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic       valid_res;
        logic [2:0] status;
    } t_out_item;

    // Result of settling the parse when the text stops.
    typedef struct packed {
        t_phase     phase;
        logic [2:0] code;
    } t_settle;

    localparam int         PREFIX_CNT  = 6;
    localparam logic [2:0] PREFIX_LAST = 3'(PREFIX_CNT - 1);
    localparam logic [2:0] STAT_MAX    = 3'd5;
    localparam logic [2:0] CODE_BAD    = 3'd6;
    localparam logic [2:0] MAG_SAT     = 3'd7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // The text "+CREG:".
    localparam logic [7:0] PREFIX_TEXT [PREFIX_CNT] = '{
        8'h2B, 8'h43, 8'h52, 8'h45, 8'h47, 8'h3A
    };

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_sign(logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    // Append one decimal digit; any value above seven saturates at seven.
    function automatic logic [2:0] add_digit(logic [2:0] mag, logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        if (mag != 3'd0 || d > 8'(MAG_SAT)) begin
            return MAG_SAT;
        end
        return d[2:0];
    endfunction

    // Code of a finished number: minus zero is zero, other negatives and values above five are bad.
    function automatic logic [2:0] number_code(logic neg, logic [2:0] mag);
        if ((neg && mag != 3'd0) || mag > STAT_MAX) begin
            return CODE_BAD;
        end
        return mag;
    endfunction

    // Settle the parse when the text stops in the given phase.
    function automatic t_settle settle(t_phase ph, logic [2:0] fc, logic neg,
                                       logic [2:0] mag);
        t_settle s;
        s.phase = PH_DONE;
        s.code  = fc;
        case (ph)
            PH_DIG1, PH_DIG2:            s.code = number_code(neg, mag);
            PH_SP1, PH_DONE:             s.code = fc;
            PH_AFTC, PH_WS2, PH_SIGN2:   s.code = 3'd0;
            default:                     s.code = CODE_BAD;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/creg_status_line_parser_unit.sv]
// Top level of the registration status line parser.
`timescale 1ns / 1ps
//
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+--------------------------
// in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// One byte is taken every cycle while o_in_stall is low; each byte passes an input register,
// then one level of parse logic that updates the phase registers and the result register.
// The result of a line is written to the result register when its line_end byte moves on.
// Synchronous active-low reset clears the phase, the counters and both valids.
// A stalled output holds only a byte that carries line_end; while it is held, the input stalls.

module creg_status_line_parser_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  crsp_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output crsp_pkg::t_out_item  o_out_data
);
    import crsp_pkg::*;

    logic       r_in_vld;
    t_in_item   r_in;
    t_phase     r_phase, n_phase;
    logic [2:0] r_match, n_match;
    logic [2:0] r_first, n_first;
    logic       r_neg, n_neg;
    logic [2:0] r_mag, n_mag;
    logic       r_out_vld;
    t_out_item  r_out, n_out;
    logic       w_adv;
    logic       w_in_take;
    logic       w_used;
    logic [7:0] w_c;
    t_settle    w_set;
    t_settle    w_end;

    // The held byte moves on unless it closes a line and the result slot is full and stalled.
    assign w_adv      = r_in_vld && (!r_in.line_end || !r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
        if (w_in_take) begin
            r_in <= i_in_data;
        end
    end

    // Parse one byte against the current phase.
    always_comb begin
        w_c     = r_in.char_in;
        n_phase = r_phase;
        n_match = r_match;
        n_first = r_first;
        n_neg   = r_neg;
        n_mag   = r_mag;
        w_used  = 1'b0;
        w_set   = settle(r_phase, r_first, r_neg, r_mag);

        if (r_phase != PH_DONE && w_c == CH_NUL) begin
            n_phase = w_set.phase;
            n_first = w_set.code;
        end else if (r_phase != PH_DONE) begin
            // Prefix search; a '+' restarts the match.
            if (n_phase == PH_PREFIX) begin
                w_used = 1'b1;
                if (n_match <= PREFIX_LAST && w_c == PREFIX_TEXT[n_match]) begin
                    if (n_match == PREFIX_LAST) begin
                        n_match = 3'd0;
                        n_phase = PH_SEP1;
                    end else begin
                        n_match = n_match + 3'd1;
                    end
                end else begin
                    n_match = (w_c == CH_PLUS) ? 3'd1 : 3'd0;
                end
            end
            // Spaces and colons after the prefix.
            if (!w_used && n_phase == PH_SEP1) begin
                if (w_c == CH_SPACE || w_c == CH_COLON) begin
                    w_used = 1'b1;
                end else begin
                    n_phase = PH_WS1;
                end
            end
            // Whitespace, then the start of the first number.
            if (!w_used && n_phase == PH_WS1) begin
                w_used = 1'b1;
                if (!is_ws(w_c)) begin
                    n_neg = 1'b0;
                    n_mag = 3'd0;
                    if (is_sign(w_c)) begin
                        n_neg   = (w_c == CH_MINUS);
                        n_phase = PH_SIGN1;
                    end else if (is_digit(w_c)) begin
                        n_mag   = add_digit(3'd0, w_c);
                        n_phase = PH_DIG1;
                    end else begin
                        n_first = CODE_BAD;
                        n_phase = PH_DONE;
                    end
                end
            end
            // A sign must be followed by a digit.
            if (!w_used && n_phase == PH_SIGN1) begin
                w_used = 1'b1;
                if (is_digit(w_c)) begin
                    n_mag   = add_digit(n_mag, w_c);
                    n_phase = PH_DIG1;
                end else begin
                    n_first = CODE_BAD;
                    n_phase = PH_DONE;
                end
            end
            // Digits of the first number.
            if (!w_used && n_phase == PH_DIG1) begin
                if (is_digit(w_c)) begin
                    w_used = 1'b1;
                    n_mag  = add_digit(n_mag, w_c);
                end else begin
                    n_first = number_code(n_neg, n_mag);
                    n_phase = PH_SP1;
                end
            end
            // Spaces before an optional comma.
            if (!w_used && n_phase == PH_SP1) begin
                w_used = 1'b1;
                if (w_c == CH_COMMA) begin
                    n_phase = PH_AFTC;
                end else if (w_c != CH_SPACE) begin
                    n_phase = PH_DONE;
                end
            end
            // After the comma: a quote keeps the first number.
            if (!w_used && n_phase == PH_AFTC) begin
                if (w_c == CH_SPACE) begin
                    w_used = 1'b1;
                end else if (w_c == CH_QUOTE) begin
                    w_used  = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_WS2;
                end
            end
            // Whitespace, then the start of the second number.
            if (!w_used && n_phase == PH_WS2) begin
                w_used = 1'b1;
                if (!is_ws(w_c)) begin
                    n_neg = 1'b0;
                    n_mag = 3'd0;
                    if (is_sign(w_c)) begin
                        n_neg   = (w_c == CH_MINUS);
                        n_phase = PH_SIGN2;
                    end else if (is_digit(w_c)) begin
                        n_mag   = add_digit(3'd0, w_c);
                        n_phase = PH_DIG2;
                    end else begin
                        n_first = 3'd0;
                        n_phase = PH_DONE;
                    end
                end
            end
            // Sign of the second number.
            if (!w_used && n_phase == PH_SIGN2) begin
                w_used = 1'b1;
                if (is_digit(w_c)) begin
                    n_mag   = add_digit(n_mag, w_c);
                    n_phase = PH_DIG2;
                end else begin
                    n_first = 3'd0;
                    n_phase = PH_DONE;
                end
            end
            // Digits of the second number.
            if (!w_used && n_phase == PH_DIG2) begin
                if (is_digit(w_c)) begin
                    n_mag = add_digit(n_mag, w_c);
                end else begin
                    n_first = number_code(n_neg, n_mag);
                    n_phase = PH_DONE;
                end
            end
        end
    end

    // The last byte of a line settles the result from the parsed state.
    always_comb begin
        w_end = settle(n_phase, n_first, n_neg, n_mag);
        n_out = '0;
        if (w_end.code <= STAT_MAX) begin
            n_out.valid_res = 1'b1;
            n_out.status    = w_end.code;
        end
    end

    // Parser state; the last byte of a line returns it to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_match <= 3'd0;
            r_first <= 3'd0;
            r_neg   <= 1'b0;
            r_mag   <= 3'd0;
        end else if (w_adv && r_in.line_end) begin
            r_phase <= PH_PREFIX;
            r_match <= 3'd0;
            r_first <= 3'd0;
            r_neg   <= 1'b0;
            r_mag   <= 3'd0;
        end else if (w_adv) begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_first <= n_first;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && r_in.line_end) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (w_adv && r_in.line_end) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`include "creg_status_line_parser_unit_macros.svh"

    // A reported status is in range, and zero when not valid.
    `CRSP_ASSERT_ALWAYS(a_status_range, !o_out_valid || o_out_data.status <= STAT_MAX)
    `CRSP_ASSERT_ALWAYS(a_idle_zero, !o_out_valid || o_out_data.valid_res || ~|o_out_data.status)
    // Bytes inside a line never hold up the input.
    `CRSP_ASSERT_ALWAYS(a_mid_line_flows, !(r_in_vld && !r_in.line_end) || !o_in_stall)
    // A closing byte that moves on yields a result transaction next cycle.
    `CRSP_ASSERT_NEXT(a_line_result, w_adv && r_in.line_end, o_out_valid)
    // The parser is back at reset after each line.
    `CRSP_ASSERT_NEXT(a_line_reset, w_adv && r_in.line_end, r_phase == PH_PREFIX && r_match == 3'd0)

endmodule
